@@ src/mat4_chain_multiply_unit_assert.svh @@
// Assertion macros for the top-level RTL; empty when SYNTHESIS is defined.
`ifndef MAT4_CHAIN_MULTIPLY_UNIT_ASSERT_SVH
`define MAT4_CHAIN_MULTIPLY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define MCM_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define MCM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MCM_ASSERT_SAME(lbl, ante, cons, msg)
`define MCM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/mcm_pkg.sv @@
`timescale 1ns / 1ps

package mcm_pkg;

   localparam int unsigned ELEMENTS          = 16;
   localparam int unsigned INDEX_BITS        = 4;
   localparam int unsigned DATA_BITS         = 32;
   localparam int unsigned PROD_BITS         = 2 * DATA_BITS;
   localparam int unsigned ACC_BITS          = PROD_BITS + 2;
   localparam int unsigned STEP_BITS         = 6;
   localparam int unsigned FRAC_BITS_DEFAULT = 16;

   typedef logic [INDEX_BITS-1:0]       index_type;
   typedef logic signed [DATA_BITS-1:0] data_type;
   typedef logic [STEP_BITS-1:0]        step_type;

   localparam index_type LAST_INDEX     = index_type'(ELEMENTS - 1);
   localparam step_type  STEP_LAST_COPY = step_type'(ELEMENTS - 1);
   localparam step_type  STEP_LAST_MUL  = step_type'(4 * ELEMENTS - 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CALC  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   // one multiply-accumulate operation travelling down the datapath
   typedef struct packed {
      logic      valid;
      logic      first;
      logic      last;
      index_type dest;
   } tag_type;

   typedef struct packed {
      logic      copy;
      index_type a_addr;
      index_type b_addr;
      tag_type   tag;
   } issue_type;

   typedef struct packed {
      logic      load;
      index_type idx;
   } emit_type;

   typedef struct packed {
      logic ready;
      logic bank;
      logic too_short;
   } status_type;

   typedef struct packed {
      logic      valid;
      index_type dest;
      data_type  value;
   } write_type;

endpackage

@@ src/mcm_ifs.sv @@
`timescale 1ns / 1ps

interface mcm_req_if;
   logic                 valid;
   logic                 ready;
   mcm_pkg::index_type   element_index;
   mcm_pkg::data_type    element_value;
   logic                 chain_end;

   modport source (output valid, element_index, element_value, chain_end, input ready);
   modport sink   (input valid, element_index, element_value, chain_end, output ready);
endinterface

interface mcm_rsp_if;
   logic                 valid;
   logic                 ready;
   mcm_pkg::index_type   result_index;
   mcm_pkg::data_type    result_value;
   logic                 last_result;
   logic                 too_short;

   modport source (output valid, result_index, result_value, last_result, too_short,
                   input ready);
   modport sink   (input valid, result_index, result_value, last_result, too_short,
                   output ready);
endinterface

@@ src/mcm_mac.sv @@
`timescale 1ns / 1ps

module mcm_mac #(
   parameter int unsigned FRAC_BITS = mcm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  mcm_pkg::data_type  a,
   input  mcm_pkg::data_type  b,
   input  mcm_pkg::tag_type   tag,
   output mcm_pkg::write_type wr,
   output logic               busy
);
   import mcm_pkg::*;

   tag_type                    tag2_ff, tag3_ff;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in, shifted;
   logic                        fits;

   assign prod_in = a * b;
   assign acc_in  = tag2_ff.first ? ACC_BITS'(prod_ff) : acc_ff + ACC_BITS'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
      end else begin
         tag2_ff.valid <= tag.valid;
         tag3_ff.valid <= tag2_ff.valid;
      end
      tag2_ff.first <= tag.first;
      tag2_ff.last  <= tag.last;
      tag2_ff.dest  <= tag.dest;
      tag3_ff.first <= tag2_ff.first;
      tag3_ff.last  <= tag2_ff.last;
      tag3_ff.dest  <= tag2_ff.dest;
      prod_ff       <= prod_in;
      if (tag2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // floor shift, then clamp to the 32-bit range
   assign shifted = acc_ff >>> FRAC_BITS;
   assign fits    = (shifted[ACC_BITS-1:DATA_BITS-1] == '0) ||
                    (shifted[ACC_BITS-1:DATA_BITS-1] == '1);

   always_comb begin
      wr.valid = tag3_ff.valid && tag3_ff.last;
      wr.dest  = tag3_ff.dest;
      if (fits) begin
         wr.value = shifted[DATA_BITS-1:0];
      end else if (shifted[ACC_BITS-1]) begin
         wr.value = {1'b1, {(DATA_BITS-1){1'b0}}};
      end else begin
         wr.value = {1'b0, {(DATA_BITS-1){1'b1}}};
      end
   end

   assign busy = tag2_ff.valid || tag3_ff.valid;

endmodule

@@ src/mcm_seq.sv @@
`timescale 1ns / 1ps

module mcm_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_xfer,
   input  mcm_pkg::index_type  req_index,
   input  logic                req_end,
   input  logic                out_free,
   input  logic                pipe_busy,
   output mcm_pkg::issue_type  issue,
   output mcm_pkg::emit_type   emit,
   output mcm_pkg::status_type status
);
   import mcm_pkg::*;

   state_type   state_ff, state_in;
   step_type    step_ff, step_in, step_last;
   logic [1:0]  seen_ff, seen_in;
   logic        copy_ff, copy_in;
   logic        end_ff, end_in;
   logic        bank_ff, bank_in;

   assign step_last = copy_ff ? STEP_LAST_COPY : STEP_LAST_MUL;

   // step bits: column, row, term for a product; element number for a copy
   always_comb begin
      issue.copy      = copy_ff;
      issue.tag.valid = (state_ff == ST_CALC);
      if (copy_ff) begin
         issue.a_addr    = step_ff[INDEX_BITS-1:0];
         issue.b_addr    = step_ff[INDEX_BITS-1:0];
         issue.tag.dest  = step_ff[INDEX_BITS-1:0];
         issue.tag.first = 1'b1;
         issue.tag.last  = 1'b1;
      end else begin
         issue.a_addr    = {step_ff[1:0], step_ff[3:2]};
         issue.b_addr    = {step_ff[5:4], step_ff[1:0]};
         issue.tag.dest  = {step_ff[5:4], step_ff[3:2]};
         issue.tag.first = (step_ff[1:0] == 2'd0);
         issue.tag.last  = (step_ff[1:0] == 2'd3);
      end
   end

   assign emit.load        = (state_ff == ST_EMIT) && out_free;
   assign emit.idx         = step_ff[INDEX_BITS-1:0];
   assign status.ready     = (state_ff == ST_IDLE);
   assign status.bank      = bank_ff;
   assign status.too_short = copy_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      seen_in  = seen_ff;
      copy_in  = copy_ff;
      end_in   = end_ff;
      bank_in  = bank_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_index == LAST_INDEX)) begin
               state_in = ST_CALC;
               step_in  = '0;
               copy_in  = (seen_ff == 2'd0);
               end_in   = req_end;
               if (req_end) begin
                  seen_in = 2'd0;
               end else if (seen_ff != 2'd2) begin
                  seen_in = seen_ff + 2'd1;
               end
            end
         end
         ST_CALC: begin
            step_in = step_ff + step_type'(1);
            if (step_ff == step_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               bank_in  = ~bank_ff;
               step_in  = '0;
               state_in = end_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               step_in = step_ff + step_type'(1);
               if (step_ff[INDEX_BITS-1:0] == LAST_INDEX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         seen_ff  <= 2'd0;
         copy_ff  <= 1'b0;
         end_ff   <= 1'b0;
         bank_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         seen_ff  <= seen_in;
         copy_ff  <= copy_in;
         end_ff   <= end_in;
         bank_ff  <= bank_in;
      end
   end

endmodule

@@ src/mat4_chain_multiply_unit.sv @@
// Elements 0..14 are accepted while ready, and the block stays ready after each.
// Element 15 holds off input for the copy of a first matrix, or 64 passes of the one
// shared multiply-accumulate unit for a later one, plus the pipeline drain; at chain
// end, 16 results follow at one per cycle while the output is ready.
// Synchronous active-high reset clears the sequencer, chain count and valids;
// the matrix stores are not cleared.
`timescale 1ns / 1ps
`include "mat4_chain_multiply_unit_assert.svh"

module mat4_chain_multiply_unit #(
   parameter int unsigned FRAC_BITS = mcm_pkg::FRAC_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   mcm_req_if.sink   req,
   mcm_rsp_if.source rsp
);
   import mcm_pkg::*;

   // fixed-point 1.0, fed as the second operand when a matrix is copied
   localparam data_type UNIT_SCALE = data_type'(DATA_BITS'(1) << FRAC_BITS);

   // incoming matrix and the two banks of the running product
   data_type   incoming_ff [ELEMENTS];
   data_type   product_ff  [2*ELEMENTS];

   issue_type  issue;
   emit_type   emit;
   status_type status;
   write_type  wr;

   data_type   a_ff, b_ff;
   tag_type    tag1_ff;
   logic       mac_busy;
   logic       req_xfer;
   logic       last_xfer;
   logic       out_free;
   logic [INDEX_BITS:0] prod_rd_addr;

   logic       rsp_valid_ff, rsp_valid_in;
   index_type  rsp_index_ff;
   data_type   rsp_value_ff;
   logic       rsp_last_ff;
   logic       rsp_short_ff;

   assign req.ready = status.ready;
   assign req_xfer  = req.valid && req.ready;
   assign last_xfer = req_xfer && (req.element_index == LAST_INDEX);

   // output register frees up when empty or when its transfer happens this cycle
   assign out_free  = !rsp_valid_ff || rsp.ready;

   mcm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_xfer  (req_xfer),
      .req_index (req.element_index),
      .req_end   (req.chain_end),
      .out_free  (out_free),
      .pipe_busy (tag1_ff.valid || mac_busy),
      .issue     (issue),
      .emit      (emit),
      .status    (status)
   );

   // one read port on the product: emission or the second operand of a pass
   assign prod_rd_addr = {status.bank, emit.load ? emit.idx : issue.b_addr};

   // store the element, then read operands for the shared unit
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         incoming_ff[req.element_index] <= req.element_value;
      end
      if (issue.tag.valid) begin
         a_ff <= incoming_ff[issue.a_addr];
         b_ff <= issue.copy ? UNIT_SCALE : product_ff[prod_rd_addr];
      end
      // finished elements go to the bank not being read
      if (wr.valid) begin
         product_ff[{~status.bank, wr.dest}] <= wr.value;
      end
      if (emit.load) begin
         rsp_value_ff <= product_ff[prod_rd_addr];
         rsp_index_ff <= emit.idx;
         rsp_last_ff  <= (emit.idx == LAST_INDEX);
         rsp_short_ff <= status.too_short;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
      end else begin
         tag1_ff.valid <= issue.tag.valid;
      end
      tag1_ff.first <= issue.tag.first;
      tag1_ff.last  <= issue.tag.last;
      tag1_ff.dest  <= issue.tag.dest;
   end

   mcm_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .a     (a_ff),
      .b     (b_ff),
      .tag   (tag1_ff),
      .wr    (wr),
      .busy  (mac_busy)
   );

   // load on emit, drop after the transfer, hold otherwise
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_index = rsp_index_ff;
   assign rsp.result_value = rsp_value_ff;
   assign rsp.last_result  = rsp_last_ff;
   assign rsp.too_short    = rsp_short_ff;

   `MCM_ASSERT_SAME(a_no_write_when_ready, wr.valid, !req.ready, "product write while ready")
   `MCM_ASSERT_NEXT(a_busy_after_final, last_xfer, !req.ready, "ready after final element")
   `MCM_ASSERT_SAME(a_pipe_needs_busy, tag1_ff.valid, !req.ready, "operands in flight while idle")
   `MCM_ASSERT_SAME(a_emit_not_writing, emit.load, !mac_busy && !tag1_ff.valid, "emit during a pass")

endmodule
